### rtl/aarm_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the rotation vector to rotation matrix converter
package aarm_pkg;

	// default cordic step count and table length
	localparam int TRIG_ITERATIONS_DEF = 30;
	localparam int ATAN_LEN            = 40;

	// digit steps of the square root and of the axis divider
	localparam int SQRT_STEPS = 32;
	localparam int DIV_STEPS  = 31;

	// angle constants in q.30
	localparam logic [32:0] HALF_PI_Q30       = 33'd1686629713;
	localparam logic [32:0] PI_Q30            = 33'd3373259426;
	localparam logic [32:0] THREE_HALF_PI_Q30 = 33'd5059889139;
	localparam logic [32:0] TWO_PI_Q30        = 33'd6746518852;

	// cordic start value and unit in q1.30
	localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;
	localparam logic signed [31:0] ONE_Q30         = 32'sd1073741824;

	// floor(atan(2^-i) * 2^30)
	localparam logic [31:0] ATAN_TAB [ATAN_LEN] = '{
		32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
		32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
		32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
		32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
		32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
		32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
		32'h00000001, 32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000,
		32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000
	};

	// input item: rotation vector in q3.28
	typedef struct packed {
		logic signed [31:0] rot_x;
		logic signed [31:0] rot_y;
		logic signed [31:0] rot_z;
	} aarm_vec_t;

	// result item: rotation matrix by rows in q1.30
	typedef struct packed {
		logic signed [31:0] m00;
		logic signed [31:0] m01;
		logic signed [31:0] m02;
		logic signed [31:0] m10;
		logic signed [31:0] m11;
		logic signed [31:0] m12;
		logic signed [31:0] m20;
		logic signed [31:0] m21;
		logic signed [31:0] m22;
	} aarm_mat_t;

endpackage

### rtl/axis_angle_to_rotation_matrix_unit.sv
`timescale 1ns / 1ps
// rotation vector to rotation matrix converter, fully pipelined
//
// An item is a rotation vector (vec, three q3.28 components) taken at each
// rising edge where start is high and busy is low. busy is held low: the
// pipeline takes one item every cycle, back to back, without gaps.
// Each item gives one 3x3 matrix in q1.30 on mat, shown for exactly one
// cycle with done high. Results leave in item order.
// The latency is set by the bit-per-stage square root (32 stages), the
// bit-per-stage axis divider (31 stages) and one cordic stage per step.
// A zero vector gives the identity matrix.
// The receiver cannot hold results off, so nothing in the pipe ever waits.
// Reset (arst_n low) clears every valid bit at once; items in flight are
// dropped and the block takes a new item in the first cycle after reset.
module axis_angle_to_rotation_matrix_unit
	import aarm_pkg::*;
#(
	parameter int TRIG_ITERATIONS = TRIG_ITERATIONS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  aarm_vec_t vec,
	output logic      done,
	output aarm_mat_t mat
);

	localparam int CORDIC_N = (TRIG_ITERATIONS > ATAN_LEN) ? ATAN_LEN : TRIG_ITERATIONS;
	localparam int LATENCY  = SQRT_STEPS + DIV_STEPS + CORDIC_N + 9;

	localparam logic signed [65:0] ONE_Q60 = 66'sd1 <<< 60;

	typedef struct packed {
		logic [35:0]      rem;
		logic [31:0]      root;
		logic [63:0]      rad;
		logic [2:0][31:0] r;
	} sq_stage_t;

	typedef struct packed {
		logic [2:0][32:0] rem;
		logic [2:0][30:0] quo;
		logic [2:0]       lsb;
		logic [2:0]       neg;
		logic [31:0]      theta;
	} dv_stage_t;

	typedef struct packed {
		logic signed [33:0] x;
		logic signed [33:0] y;
		logic signed [34:0] z;
		logic [2:0][31:0]   k;
		logic               flip;
		logic               zero;
	} cd_stage_t;

	// clamp a cordic output to [-1, 1]
	function automatic logic [31:0] clamp_cd(input logic signed [33:0] v);
		logic [31:0] res;
		if (v > 34'sd1073741824) begin
			res = ONE_Q30;
		end else if (v < -34'sd1073741824) begin
			res = -ONE_Q30;
		end else begin
			res = v[31:0];
		end
		return res;
	endfunction

	// round a q.60 sum to q1.30 and clamp to [-1, 1]
	function automatic logic [31:0] round_q30(input logic signed [65:0] v);
		logic signed [65:0] t;
		logic signed [65:0] s;
		logic [31:0]        res;
		t = v + (66'sd1 <<< 29);
		s = t >>> 30;
		if (s > 66'sd1073741824) begin
			res = ONE_Q30;
		end else if (s < -66'sd1073741824) begin
			res = -ONE_Q30;
		end else begin
			res = s[31:0];
		end
		return res;
	endfunction

	logic in_acc;

	assign busy   = 1'b0;
	assign in_acc = start && !busy;

	// stage 1: squares of the components
	logic [2:0][31:0] rin;
	logic [2:0][63:0] sqr;
	logic             v_s1;
	logic [2:0][31:0] r_s1;
	logic [2:0][62:0] sqr_s1;

	assign rin = {vec.rot_z, vec.rot_y, vec.rot_x};

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			sqr[c] = $signed(rin[c]) * $signed(rin[c]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= in_acc;
		end
	end

	always_ff @(posedge clk) begin
		r_s1 <= rin;
		for (int c = 0; c < 3; c++) begin
			sqr_s1[c] <= sqr[c][62:0];
		end
	end

	// stage 2: sum of squares
	logic             v_s2;
	logic [2:0][31:0] r_s2;
	logic [63:0]      sum_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		r_s2   <= r_s1;
		sum_s2 <= {1'b0, sqr_s1[0]} + {1'b0, sqr_s1[1]} + {1'b0, sqr_s1[2]};
	end

	// square root, one result bit per stage
	sq_stage_t sq_s [SQRT_STEPS+1];
	logic      sq_v [SQRT_STEPS+1];

	always_comb begin
		sq_s[0].rem  = '0;
		sq_s[0].root = '0;
		sq_s[0].rad  = sum_s2;
		sq_s[0].r    = r_s2;
		sq_v[0]      = v_s2;
	end

	for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
		localparam int K = SQRT_STEPS - 1 - j;
		logic [35:0] rem_sh;
		logic [35:0] trial;
		logic        fits;
		sq_stage_t   nxt;

		always_comb begin
			rem_sh   = {sq_s[j].rem[33:0], sq_s[j].rad[2*K+1 -: 2]};
			trial    = {2'b00, sq_s[j].root, 2'b01};
			fits     = rem_sh >= trial;
			nxt      = sq_s[j];
			nxt.rem  = fits ? rem_sh - trial : rem_sh;
			nxt.root = {sq_s[j].root[30:0], fits};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_v[j+1] <= 1'b0;
			end else begin
				sq_v[j+1] <= sq_v[j];
			end
		end

		always_ff @(posedge clk) begin
			sq_s[j+1] <= nxt;
		end
	end

	// unit axis: three restoring dividers, one quotient bit per stage
	dv_stage_t        dv_s [DIV_STEPS+1];
	logic             dv_v [DIV_STEPS+1];
	logic [2:0][31:0] dv_mag;

	always_comb begin
		dv_s[0].theta = sq_s[SQRT_STEPS].root;
		dv_v[0]       = sq_v[SQRT_STEPS];
		for (int c = 0; c < 3; c++) begin
			dv_s[0].neg[c] = sq_s[SQRT_STEPS].r[c][31];
			dv_mag[c]      = dv_s[0].neg[c] ? 32'd0 - sq_s[SQRT_STEPS].r[c]
			                                : sq_s[SQRT_STEPS].r[c];
			dv_s[0].rem[c] = {2'b00, dv_mag[c][31:1]};
			dv_s[0].lsb[c] = dv_mag[c][0];
			dv_s[0].quo[c] = '0;
		end
	end

	for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
		logic [2:0][32:0] rem_sh;
		logic [2:0]       ge;
		dv_stage_t        nxt;

		always_comb begin
			nxt = dv_s[j];
			for (int c = 0; c < 3; c++) begin
				rem_sh[c]  = {dv_s[j].rem[c][31:0], (j == 0) ? dv_s[j].lsb[c] : 1'b0};
				ge[c]      = rem_sh[c] >= {1'b0, dv_s[j].theta};
				nxt.rem[c] = ge[c] ? rem_sh[c] - {1'b0, dv_s[j].theta} : rem_sh[c];
				nxt.quo[c] = {dv_s[j].quo[c][29:0], ge[c]};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v[j+1] <= 1'b0;
			end else begin
				dv_v[j+1] <= dv_v[j];
			end
		end

		always_ff @(posedge clk) begin
			dv_s[j+1] <= nxt;
		end
	end

	// stage 3: signed axis, angle modulo two pi
	logic             v_s3;
	logic [2:0][31:0] k_s3;
	logic [32:0]      ang_s3;
	logic             zero_s3;
	logic [32:0]      twice;

	assign twice = {dv_s[DIV_STEPS].theta, 1'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= dv_v[DIV_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		for (int c = 0; c < 3; c++) begin
			k_s3[c] <= dv_s[DIV_STEPS].neg[c] ? 32'd0 - {1'b0, dv_s[DIV_STEPS].quo[c]}
			                                  : {1'b0, dv_s[DIV_STEPS].quo[c]};
		end
		ang_s3  <= (twice >= TWO_PI_Q30) ? twice - TWO_PI_Q30 : twice;
		zero_s3 <= dv_s[DIV_STEPS].theta == 32'd0;
	end

	// fold into [-pi/2, pi/2]; an odd multiple of pi flips the signs
	cd_stage_t cd_s [CORDIC_N+1];
	logic      cd_v [CORDIC_N+1];
	cd_stage_t cd_first;

	always_comb begin
		cd_first.x    = CORDIC_GAIN_Q30;
		cd_first.y    = '0;
		cd_first.k    = k_s3;
		cd_first.zero = zero_s3;
		priority if (ang_s3 <= HALF_PI_Q30) begin
			cd_first.z    = {2'b00, ang_s3};
			cd_first.flip = 1'b0;
		end else if (ang_s3 < THREE_HALF_PI_Q30) begin
			cd_first.z    = {2'b00, ang_s3} - {2'b00, PI_Q30};
			cd_first.flip = 1'b1;
		end else begin
			cd_first.z    = {2'b00, ang_s3} - {2'b00, TWO_PI_Q30};
			cd_first.flip = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cd_v[0] <= 1'b0;
		end else begin
			cd_v[0] <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		cd_s[0] <= cd_first;
	end

	// cordic rotation, one step per stage
	for (genvar i = 0; i < CORDIC_N; i++) begin : g_cordic
		logic signed [33:0] dx;
		logic signed [33:0] dy;
		logic signed [34:0] at;
		cd_stage_t          nxt;

		always_comb begin
			dx  = $signed(cd_s[i].y) >>> i;
			dy  = $signed(cd_s[i].x) >>> i;
			at  = $signed({3'b000, ATAN_TAB[i]});
			nxt = cd_s[i];
			if (!cd_s[i].z[34]) begin
				nxt.x = cd_s[i].x - dx;
				nxt.y = cd_s[i].y + dy;
				nxt.z = cd_s[i].z - at;
			end else begin
				nxt.x = cd_s[i].x + dx;
				nxt.y = cd_s[i].y - dy;
				nxt.z = cd_s[i].z + at;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				cd_v[i+1] <= 1'b0;
			end else begin
				cd_v[i+1] <= cd_v[i];
			end
		end

		always_ff @(posedge clk) begin
			cd_s[i+1] <= nxt;
		end
	end

	// stage 4: sign flip and clamp of cos and sin
	logic               v_s4;
	logic [31:0]        w_s4;
	logic [31:0]        sn_s4;
	logic [2:0][31:0]   k_s4;
	logic               zero_s4;
	logic signed [33:0] cx;
	logic signed [33:0] cy;

	always_comb begin
		cx = cd_s[CORDIC_N].flip ? -cd_s[CORDIC_N].x : cd_s[CORDIC_N].x;
		cy = cd_s[CORDIC_N].flip ? -cd_s[CORDIC_N].y : cd_s[CORDIC_N].y;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else begin
			v_s4 <= cd_v[CORDIC_N];
		end
	end

	always_ff @(posedge clk) begin
		w_s4    <= clamp_cd(cx);
		sn_s4   <= clamp_cd(cy);
		k_s4    <= cd_s[CORDIC_N].k;
		zero_s4 <= cd_s[CORDIC_N].zero;
	end

	// stage 5: axis times sine
	logic             v_s5;
	logic [2:0][63:0] kp_s5;
	logic [31:0]      w_s5;
	logic             zero_s5;
	logic [2:0][63:0] kp;

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			kp[c] = $signed(k_s4[c]) * $signed(sn_s4);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		kp_s5   <= kp;
		w_s5    <= w_s4;
		zero_s5 <= zero_s4;
	end

	// stage 6: quaternion products xx yy zz xy xz yz xw yw zw
	logic             v_s6;
	logic [8:0][63:0] pp_s6;
	logic             zero_s6;
	logic [2:0][31:0] q;
	logic [8:0][63:0] pp;

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			q[c] = kp_s5[c][61:30];
		end
		pp[0] = $signed(q[0]) * $signed(q[0]);
		pp[1] = $signed(q[1]) * $signed(q[1]);
		pp[2] = $signed(q[2]) * $signed(q[2]);
		pp[3] = $signed(q[0]) * $signed(q[1]);
		pp[4] = $signed(q[0]) * $signed(q[2]);
		pp[5] = $signed(q[1]) * $signed(q[2]);
		pp[6] = $signed(q[0]) * $signed(w_s5);
		pp[7] = $signed(q[1]) * $signed(w_s5);
		pp[8] = $signed(q[2]) * $signed(w_s5);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		pp_s6   <= pp;
		zero_s6 <= zero_s5;
	end

	// stage 7: matrix entries in q.60
	logic                     v_s7;
	logic signed [8:0][65:0]  e_s7;
	logic                     zero_s7;
	logic signed [8:0][65:0]  px;
	logic signed [8:0][65:0]  e;

	always_comb begin
		for (int c = 0; c < 9; c++) begin
			px[c] = {{2{pp_s6[c][63]}}, pp_s6[c]};
		end
		e[0] = ONE_Q60 - ((px[1] + px[2]) <<< 1);
		e[1] = (px[3] - px[8]) <<< 1;
		e[2] = (px[4] + px[7]) <<< 1;
		e[3] = (px[3] + px[8]) <<< 1;
		e[4] = ONE_Q60 - ((px[0] + px[2]) <<< 1);
		e[5] = (px[5] - px[6]) <<< 1;
		e[6] = (px[4] - px[7]) <<< 1;
		e[7] = (px[5] + px[6]) <<< 1;
		e[8] = ONE_Q60 - ((px[0] + px[1]) <<< 1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else begin
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		e_s7    <= e;
		zero_s7 <= zero_s6;
	end

	// output register: rounding, clamp, identity for a zero vector
	aarm_mat_t mat_nxt;

	always_comb begin
		if (zero_s7) begin
			mat_nxt     = '0;
			mat_nxt.m00 = ONE_Q30;
			mat_nxt.m11 = ONE_Q30;
			mat_nxt.m22 = ONE_Q30;
		end else begin
			mat_nxt.m00 = round_q30(e_s7[0]);
			mat_nxt.m01 = round_q30(e_s7[1]);
			mat_nxt.m02 = round_q30(e_s7[2]);
			mat_nxt.m10 = round_q30(e_s7[3]);
			mat_nxt.m11 = round_q30(e_s7[4]);
			mat_nxt.m12 = round_q30(e_s7[5]);
			mat_nxt.m20 = round_q30(e_s7[6]);
			mat_nxt.m21 = round_q30(e_s7[7]);
			mat_nxt.m22 = round_q30(e_s7[8]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		mat <= mat_nxt;
	end

`ifndef SYNTHESIS
	// every result traces back to an earlier item with start high
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LATENCY))
		else $error("result without a matching item");

	// square root remainder stays within twice the root
	a_sqrt_rem: assert property (@(posedge clk) disable iff (!arst_n)
		sq_v[SQRT_STEPS] |->
			sq_s[SQRT_STEPS].rem <= {3'b000, sq_s[SQRT_STEPS].root, 1'b0})
		else $error("square root remainder out of range");

	// divider remainders end below the divisor
	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		dv_v[DIV_STEPS] && (dv_s[DIV_STEPS].theta != 32'd0) |->
			(dv_s[DIV_STEPS].rem[0] < {1'b0, dv_s[DIV_STEPS].theta}) &&
			(dv_s[DIV_STEPS].rem[1] < {1'b0, dv_s[DIV_STEPS].theta}) &&
			(dv_s[DIV_STEPS].rem[2] < {1'b0, dv_s[DIV_STEPS].theta}))
		else $error("divider remainder not reduced");

	// a zero vector comes out as the identity
	a_identity: assert property (@(posedge clk) disable iff (!arst_n)
		done && $past(zero_s7) |->
			(mat.m00 == ONE_Q30) && (mat.m01 == 32'sd0) && (mat.m22 == ONE_Q30))
		else $error("zero vector did not give the identity");
`endif

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// self-checking bench for the rotation vector to rotation matrix converter
module testbench
	import aarm_pkg::*;
();

	localparam int LATENCY = 72 + TRIG_ITERATIONS_DEF;

	logic      clk;
	logic      arst_n;
	logic      start;
	logic      busy;
	aarm_vec_t vec;
	logic      done;
	aarm_mat_t mat;

	aarm_mat_t matrix_q[$];
	int        errors;
	int        idle_pct;

	axis_angle_to_rotation_matrix_unit u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.vec(vec), .done(done), .mat(mat)
	);

	// clock
	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// floor division by 2^s of a signed value
	function automatic longint fshift(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint clamp1(longint v);
		if (v > 64'sd1073741824) return 64'sd1073741824;
		if (v < -64'sd1073741824) return -64'sd1073741824;
		return v;
	endfunction

	function automatic longint round_q30(longint v60);
		return clamp1(fshift(v60 + (64'sd1 <<< 29), 30));
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned n);
		longint unsigned res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > n) b = b >> 2;
		while (b != 0) begin
			if (n >= res + b) begin
				n = n - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	function automatic longint axis_comp(longint r, longint unsigned th);
		longint unsigned mag;
		longint q;
		mag = (r < 0) ? longint'(-r) : longint'(r);
		q = longint'((mag << 30) / th);
		return (r < 0) ? -q : q;
	endfunction

	// expected matrix for one rotation vector
	function automatic aarm_mat_t rotation_of(aarm_vec_t v);
		longint rx, ry, rz, a, cx, cy, z, dx, dy, kx, ky, kz, w, qx, qy, qz;
		longint unsigned sum, th;
		longint m[9];
		longint pi, one60;
		bit flip;
		int n;
		aarm_mat_t res;
		rx = v.rot_x;
		ry = v.rot_y;
		rz = v.rot_z;
		pi = longint'(PI_Q30);
		one60 = 64'sd1 <<< 60;
		flip = 1'b0;
		sum = rx * rx + ry * ry + rz * rz;
		th = int_sqrt(sum);
		if (th == 0) begin
			for (int j = 0; j < 9; j++) m[j] = (j % 4 == 0) ? 64'sd1073741824 : 0;
		end else begin
			kx = axis_comp(rx, th);
			ky = axis_comp(ry, th);
			kz = axis_comp(rz, th);
			a = longint'((th * 2) % longint'(2 * pi));
			if (a > pi) a = a - 2 * pi;
			if (a > longint'(HALF_PI_Q30)) begin
				a = a - pi;
				flip = 1'b1;
			end else if (a < -longint'(HALF_PI_Q30)) begin
				a = a + pi;
				flip = 1'b1;
			end
			n = (TRIG_ITERATIONS_DEF > ATAN_LEN) ? ATAN_LEN : TRIG_ITERATIONS_DEF;
			cx = longint'(CORDIC_GAIN_Q30);
			cy = 0;
			z = a;
			for (int i = 0; i < n; i++) begin
				dx = fshift(cy, i);
				dy = fshift(cx, i);
				if (z >= 0) begin
					cx = cx - dx;
					cy = cy + dy;
					z = z - longint'(ATAN_TAB[i]);
				end else begin
					cx = cx + dx;
					cy = cy - dy;
					z = z + longint'(ATAN_TAB[i]);
				end
			end
			if (flip) begin
				cx = -cx;
				cy = -cy;
			end
			w = clamp1(cx);
			cy = clamp1(cy);
			qx = fshift(kx * cy, 30);
			qy = fshift(ky * cy, 30);
			qz = fshift(kz * cy, 30);
			m[0] = round_q30(one60 - 2 * (qy * qy + qz * qz));
			m[1] = round_q30(2 * (qx * qy - qz * w));
			m[2] = round_q30(2 * (qx * qz + qy * w));
			m[3] = round_q30(2 * (qx * qy + qz * w));
			m[4] = round_q30(one60 - 2 * (qx * qx + qz * qz));
			m[5] = round_q30(2 * (qy * qz - qx * w));
			m[6] = round_q30(2 * (qx * qz - qy * w));
			m[7] = round_q30(2 * (qy * qz + qx * w));
			m[8] = round_q30(one60 - 2 * (qx * qx + qy * qy));
		end
		res.m00 = m[0][31:0]; res.m01 = m[1][31:0]; res.m02 = m[2][31:0];
		res.m10 = m[3][31:0]; res.m11 = m[4][31:0]; res.m12 = m[5][31:0];
		res.m20 = m[6][31:0]; res.m21 = m[7][31:0]; res.m22 = m[8][31:0];
		return res;
	endfunction

	// send one item, with random idle cycles before it
	task automatic send_vec(aarm_vec_t v);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		vec   <= v;
		@(posedge clk);
		while (busy) @(posedge clk);
		matrix_q.push_back(rotation_of(v));
	endtask

	function automatic logic signed [31:0] rand_comp();
		case ($urandom_range(3))
			0: return $urandom;
			1: return $signed($urandom_range(32'h1000_0000)) - 32'sh0800_0000;
			2: return $signed($urandom_range(32'h0000_1000)) - 32'sh0000_0800;
			default: return $signed($urandom_range(32'h6000_0000)) - 32'sh3000_0000;
		endcase
	endfunction

	// compare each result with the oldest expectation
	always @(posedge clk) begin
		aarm_mat_t exp_m;
		if (arst_n && done) begin
			if (matrix_q.size() == 0) begin
				$display("%0t: unexpected result %h", $time, mat);
				errors++;
			end else begin
				exp_m = matrix_q.pop_front();
				for (int f = 0; f < 9; f++) begin
					if (exp_m[f*32 +: 32] !== mat[f*32 +: 32]) begin
						$display("%0t: entry %0d expected %h actual %h", $time,
							8 - f, exp_m[f*32 +: 32], mat[f*32 +: 32]);
						errors++;
					end
				end
			end
		end
	end

	// extremes, small and unit components, the zero vector and a turn by pi
	task automatic test_directed();
		logic signed [31:0] ext[6];
		aarm_vec_t v;
		ext = '{32'sh8000_0000, 32'sh7fff_ffff, 0, 1, -1, 32'sh1000_0000};
		idle_pct = 0;
		send_vec('0);
		for (int i = 0; i < 6; i++) begin
			v = '0; v.rot_x = ext[i]; send_vec(v);
			v = '0; v.rot_y = ext[i]; send_vec(v);
			v = '0; v.rot_z = ext[i]; send_vec(v);
		end
		v.rot_x = 32'sh8000_0000; v.rot_y = 32'sh8000_0000; v.rot_z = 32'sh8000_0000;
		send_vec(v);
		v.rot_x = 32'sh7fff_ffff; v.rot_y = 32'sh7fff_ffff; v.rot_z = 32'sh7fff_ffff;
		send_vec(v);
		v.rot_x = 32'sh3243_f6a9; v.rot_y = 0; v.rot_z = 0;
		send_vec(v);
	endtask

	// random vectors over several idle settings
	task automatic test_random();
		int pcts[4];
		aarm_vec_t v;
		pcts = '{0, 51, 0, 35};
		for (int p = 0; p < 4; p++) begin
			idle_pct = pcts[p];
			for (int i = 0; i < 450; i++) begin
				v.rot_x = rand_comp();
				v.rot_y = rand_comp();
				v.rot_z = rand_comp();
				send_vec(v);
			end
		end
	endtask

	initial begin
		errors   = 0;
		idle_pct = 0;
		arst_n   = 1'b0;
		start    = 1'b0;
		vec      = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random();
		start <= 1'b0;
		while (matrix_q.size() != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// overall time limit
	initial begin
		#2000000;
		$display("DONE: errors detected");
		$finish;
	end
endmodule
